>>> design/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the pure pursuit steering core.
// ----------------------------------------------------------------------------
package pps_pkg;

    // input word operation codes
    localparam logic OP_WAYPOINT = 1'b0;
    localparam logic OP_POSE     = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_GAIN      = 2'd1;
    localparam logic [1:0] REG_WHEELBASE = 2'd2;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 20;
    localparam int CNT_W        = 5;
    localparam int CX_W         = 40;
    localparam int CZ_W         = 36;

    localparam logic signed [CZ_W-1:0] QUARTER_TURN = 36'sd1073741824;
    localparam logic signed [CZ_W-1:0] HALF_TURN    = 36'sd2147483648;
    localparam logic signed [CX_W-1:0] GAIN_Q30     = 40'sd652032874;
    localparam logic [32:0]            BEAR_LIMIT   = 33'd1415524461;

    localparam logic [8:0] SPEED_HIT   = 9'd384;
    localparam int         WINDOW_HALF = 512;
    localparam int         REMAIN_MIN  = 10;

    typedef struct packed {
        logic start;
        logic rotate;   // 1: rotation (sine), 0: vectoring (atan2)
    } cordic_cmd_t;

    function automatic logic signed [CZ_W-1:0] atan_tab(input logic [CNT_W-1:0] idx);
        logic signed [CZ_W-1:0] v;
        unique case (idx)
            5'd0:    v = 36'sd536870912;
            5'd1:    v = 36'sd316933406;
            5'd2:    v = 36'sd167458907;
            5'd3:    v = 36'sd85004756;
            5'd4:    v = 36'sd42667331;
            5'd5:    v = 36'sd21354465;
            5'd6:    v = 36'sd10680862;
            5'd7:    v = 36'sd5340757;
            5'd8:    v = 36'sd2670675;
            5'd9:    v = 36'sd1335087;
            5'd10:   v = 36'sd667544;
            5'd11:   v = 36'sd333772;
            5'd12:   v = 36'sd166886;
            5'd13:   v = 36'sd83443;
            5'd14:   v = 36'sd41722;
            5'd15:   v = 36'sd20861;
            5'd16:   v = 36'sd10430;
            5'd17:   v = 36'sd5215;
            5'd18:   v = 36'sd2608;
            5'd19:   v = 36'sd1304;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/pps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> design/pps_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation.
// ----------------------------------------------------------------------------
module pps_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pps_pkg::cordic_cmd_t               cmd,
    input  logic signed [pps_pkg::CX_W-1:0]    x_in,
    input  logic signed [pps_pkg::CX_W-1:0]    y_in,
    input  logic signed [pps_pkg::CZ_W-1:0]    z_in,
    output logic                               done,
    output logic signed [pps_pkg::CX_W-1:0]    y_out,
    output logic signed [pps_pkg::CZ_W-1:0]    z_out
);
    import pps_pkg::*;

    logic signed [CX_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [CZ_W-1:0] z_reg, z_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   run_reg, rot_reg, done_reg;
    logic signed [CX_W-1:0] xs, ys;
    logic signed [CZ_W-1:0] at;

    always_comb
    begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = atan_tab(cnt_reg);
        if (rot_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
        end
        else
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rot_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(CORDIC_STEPS - 1));
            if (cmd.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rot_reg <= cmd.rotate;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

>>> design/pps_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pps_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [49:0] value,
    output logic        done,
    output logic [24:0] root
);
    logic [49:0] v_reg, r_reg, bit_reg;
    logic        run_reg, done_reg;
    logic [50:0] trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (bit_reg == 50'd1);
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (bit_reg == 50'd1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 50'd1 << 48;
        end
        else if (run_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= v_reg - trial[49:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[24:0];
endmodule

>>> design/pps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] dividend,
    input  logic [46:0] divisor,
    output logic        done,
    output logic [55:0] quotient
);
    logic [55:0] q_reg;
    logic [46:0] d_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg, done_reg;
    logic [47:0] rem_sh, diff;

    assign rem_sh = {rem_reg, q_reg[55]};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 6'd55);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd55)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_reg <= diff[46:0];
                q_reg   <= {q_reg[54:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[46:0];
                q_reg   <= {q_reg[54:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

>>> design/pure_pursuit_steering_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_steering_core
// Waypoint store plus pure pursuit goal search and steering command.
// ----------------------------------------------------------------------------
// A waypoint word (operation 0) is written to the store, while it has
// room, in the cycle it is taken and never raises busy. A pose word
// (operation 1) raises busy until its one result word, which sits on
// the outputs for exactly one cycle with done high; the receiver cannot
// stall it, so capture it then.
// The scan starts at the remembered goal and reads one waypoint per visit
// from the store's single read port; each waypoint that falls in the
// distance window runs a 20-step bearing CORDIC. The tail is a 20-step
// sine CORDIC, a square root, a divider and a 20-step arctangent CORDIC,
// on iterative units with one CORDIC shared by all three. A miss ends right
// after the scan; a goal at zero distance ends after the square root.
// Configuration writes go in only while busy is low; the user must keep to this, the core does not enforce it.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_core #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic               last_point,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic [8:0]         speed_cmd,
    output logic signed [15:0] steering_cmd,
    output logic               goal_found,
    output logic [9:0]         goal_position,
    output logic               stop_request,
    output logic               path_available
);
    import pps_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LO   = 5'd1;   // lower window bound squared
    localparam logic [4:0] S_HI   = 5'd2;   // upper window bound plus one, squared
    localparam logic [4:0] S_HI2  = 5'd3;
    localparam logic [4:0] S_RD   = 5'd4;   // issue waypoint read
    localparam logic [4:0] S_DX   = 5'd5;
    localparam logic [4:0] S_SQX  = 5'd6;
    localparam logic [4:0] S_SQY  = 5'd7;
    localparam logic [4:0] S_CMP  = 5'd8;   // distance window test
    localparam logic [4:0] S_BEAR = 5'd9;   // bearing CORDIC
    localparam logic [4:0] S_SIN  = 5'd10;
    localparam logic [4:0] S_SQRT = 5'd11;
    localparam logic [4:0] S_KW   = 5'd12;
    localparam logic [4:0] S_NUM  = 5'd13;
    localparam logic [4:0] S_DIVS = 5'd14;
    localparam logic [4:0] S_DIV  = 5'd15;
    localparam logic [4:0] S_ATN  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0]  state_reg;

    // configuration
    logic [15:0] look_reg;
    logic [11:0] gain_reg;
    logic [10:0] wb_reg;

    // path bookkeeping
    logic [CW-1:0] load_pos_reg, path_count_reg, i_reg;
    logic [AW-1:0] last_goal_reg, goal_reg, last_goal_next;

    // pose and scan datapath
    logic signed [23:0] px_reg, py_reg;
    logic signed [15:0] yaw_reg, wyaw_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [33:0]        lo2_reg, hi2_reg;
    logic [49:0]        sq_reg, sum_reg;
    logic               zero_off_reg;
    logic signed [CX_W-1:0] s_reg;
    logic [24:0]        dist_reg;
    logic               num_neg_reg, hit_reg;
    logic signed [15:0] steer_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // output word
    logic               done_reg, found_reg, stop_reg, avail_reg;
    logic [8:0]         speed_reg;
    logic [9:0]         gpos_reg;
    logic signed [15:0] steer_out_reg;

    logic accept_way, accept_pose, ram_we;
    logic [23:0] rd_x, rd_y;
    logic [15:0] rd_yaw;

    assign accept_way  = start && !busy && (operation == OP_WAYPOINT);
    assign accept_pose = start && !busy && (operation == OP_POSE);
    assign ram_we      = accept_way && (load_pos_reg < CW'(MAX_WAYPOINTS));
    assign busy        = (state_reg != S_IDLE);

    pps_ram #(.WIDTH(24), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
        .clk(clk), .we(ram_we), .waddr(load_pos_reg[AW-1:0]), .wdata(pos_x),
        .raddr(i_reg[AW-1:0]), .rdata(rd_x)
    );
    pps_ram #(.WIDTH(24), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
        .clk(clk), .we(ram_we), .waddr(load_pos_reg[AW-1:0]), .wdata(pos_y),
        .raddr(i_reg[AW-1:0]), .rdata(rd_y)
    );
    pps_ram #(.WIDTH(16), .DEPTH(MAX_WAYPOINTS)) u_ram_yaw (
        .clk(clk), .we(ram_we), .waddr(load_pos_reg[AW-1:0]), .wdata(heading),
        .raddr(i_reg[AW-1:0]), .rdata(rd_yaw)
    );

    // window bounds: floor(sqrt(s)) in [lo, hi] <=> s >= lo^2 (lo > 0), s < (hi+1)^2
    logic signed [17:0] lo_b, hi1_b;
    assign lo_b  = $signed({2'b00, look_reg}) - 18'sd512;
    assign hi1_b = $signed({2'b00, look_reg}) + 18'sd513;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LO:
            begin
                mul_a = 33'(lo_b);
                mul_b = 33'(lo_b);
            end
            S_HI:
            begin
                mul_a = 33'(hi1_b);
                mul_b = 33'(hi1_b);
            end
            S_SQX:
            begin
                mul_a = 33'(dx_reg);
                mul_b = 33'(dx_reg);
            end
            S_SQY:
            begin
                mul_a = 33'(dy_reg);
                mul_b = 33'(dy_reg);
            end
            S_KW:
            begin
                mul_a = $signed({21'd0, gain_reg});
                mul_b = $signed({22'd0, wb_reg});
            end
            S_NUM:
            begin
                mul_a = prod_reg[32:0];
                mul_b = s_reg[32:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // window test
    logic [49:0] sum_sq;
    logic        in_win;
    assign sum_sq = sq_reg + prod_reg[49:0];
    assign in_win = ((lo_b <= 0) || (sum_sq >= {16'd0, lo2_reg}))
                    && (sum_sq < {16'd0, hi2_reg});

    // bearing pre-rotation into the right half plane
    logic signed [CX_W-1:0] bx0, by0;
    logic signed [CZ_W-1:0] bz0;
    always_comb
    begin
        bx0 = CX_W'(dx_reg);
        by0 = CX_W'(dy_reg);
        bz0 = '0;
        if (dx_reg < 0)
        begin
            if (dy_reg >= 0)
            begin
                bx0 = CX_W'(dy_reg);
                by0 = -CX_W'(dx_reg);
                bz0 = QUARTER_TURN;
            end
            else
            begin
                bx0 = -CX_W'(dy_reg);
                by0 = CX_W'(dx_reg);
                bz0 = -QUARTER_TURN;
            end
        end
    end

    // CORDIC and iterative units
    cordic_cmd_t            c_cmd;
    logic signed [CX_W-1:0] c_x, c_y, c_yo;
    logic signed [CZ_W-1:0] c_z, c_zo;
    logic                   c_done, sq_start, sq_done, dv_start, dv_done;
    logic [24:0]            sq_root;
    logic [55:0]            dv_dividend, dv_q;
    logic [46:0]            dv_divisor;

    pps_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .cmd(c_cmd), .x_in(c_x), .y_in(c_y), .z_in(c_z),
        .done(c_done), .y_out(c_yo), .z_out(c_zo)
    );
    pps_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .value(sum_reg),
        .done(sq_done), .root(sq_root)
    );
    pps_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .done(dv_done), .quotient(dv_q)
    );

    // bearing check relative to heading, wrapped to 32 bits
    logic signed [CZ_W-1:0] bear_z, bdiff;
    logic signed [31:0]     b32;
    logic [32:0]            babs;
    logic                   bear_ok;
    assign bear_z  = zero_off_reg ? '0 : c_zo;
    assign bdiff   = bear_z - (CZ_W'(yaw_reg) <<< 16);
    assign b32     = bdiff[31:0];
    assign babs    = b32[31] ? (33'd0 - {1'b1, b32}) : {1'b0, b32};
    assign bear_ok = (babs <= BEAR_LIMIT);

    // sine argument folded into [-pi/2, pi/2]
    logic [15:0]            adiff;
    logic signed [CZ_W-1:0] za, zf;
    assign adiff = wyaw_reg - yaw_reg;
    assign za    = CZ_W'($signed({adiff, 16'h0000}));
    always_comb
    begin
        if (za > QUARTER_TURN)
            zf = HALF_TURN - za;
        else if (za < -QUARTER_TURN)
            zf = -HALF_TURN - za;
        else
            zf = za;
    end

    // numerator 2*k*wb*S and signed quotient
    logic [55:0]            num56, num_mag, q_signed;
    assign num56    = {prod_reg[54:0], 1'b0};
    assign num_mag  = num56[55] ? (56'd0 - num56) : num56;
    assign q_signed = num_neg_reg ? (56'd0 - dv_q) : dv_q;

    // steering clamp
    logic signed [CZ_W-1:0] zsh;
    logic signed [15:0]     steer_clamp;
    assign zsh = c_zo >>> 15;
    always_comb
    begin
        if (zsh > 36'sd32767)
            steer_clamp = 16'sh7FFF;
        else if (zsh < -36'sd32768)
            steer_clamp = 16'sh8000;
        else
            steer_clamp = zsh[15:0];
    end

    always_comb
    begin
        c_cmd       = '{start: 1'b0, rotate: 1'b0};
        c_x         = bx0;
        c_y         = by0;
        c_z         = bz0;
        sq_start    = 1'b0;
        dv_start    = 1'b0;
        dv_dividend = num_mag;
        dv_divisor  = {dist_reg, 22'd0};
        unique case (state_reg)
            S_CMP:
            begin
                c_cmd.start = in_win;
            end
            S_BEAR:
            begin
                c_cmd = '{start: c_done && bear_ok, rotate: 1'b1};
                c_x   = GAIN_Q30;
                c_y   = '0;
                c_z   = zf;
            end
            S_SIN:
            begin
                sq_start = c_done;
            end
            S_DIVS:
            begin
                dv_start = 1'b1;
            end
            S_DIV:
            begin
                c_cmd.start = dv_done;
                c_x         = 40'sd65536;
                c_y         = q_signed[CX_W-1:0];
                c_z         = '0;
            end
            default:
            begin
                c_cmd = '{start: 1'b0, rotate: 1'b0};
            end
        endcase
    end

    assign last_goal_next = hit_reg ? goal_reg : last_goal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            look_reg       <= 16'd1536;
            gain_reg       <= 12'd256;
            wb_reg         <= 11'd448;
            load_pos_reg   <= '0;
            path_count_reg <= '0;
            last_goal_reg  <= '0;
            i_reg          <= '0;
            hit_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_LOOKAHEAD: look_reg <= cfg_data;
                    REG_GAIN:      gain_reg <= cfg_data[11:0];
                    REG_WHEELBASE: wb_reg   <= cfg_data[10:0];
                    default:       ;
                endcase
            end
            if (accept_way)
            begin
                if (ram_we)
                begin
                    path_count_reg <= load_pos_reg + 1'b1;
                    load_pos_reg   <= last_point ? '0 : load_pos_reg + 1'b1;
                end
                else
                begin
                    path_count_reg <= load_pos_reg;
                    if (last_point)
                        load_pos_reg <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_pose)
                    begin
                        i_reg     <= CW'(last_goal_reg);
                        hit_reg   <= 1'b0;
                        state_reg <= S_LO;
                    end
                end
                S_LO:   state_reg <= S_HI;
                S_HI:   state_reg <= S_HI2;
                S_HI2:  state_reg <= S_RD;
                S_RD:   state_reg <= (i_reg >= path_count_reg) ? S_OUT : S_DX;
                S_DX:   state_reg <= S_SQX;
                S_SQX:  state_reg <= S_SQY;
                S_SQY:  state_reg <= S_CMP;
                S_CMP:
                begin
                    if (in_win)
                    begin
                        state_reg <= S_BEAR;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_BEAR:
                begin
                    if (c_done)
                    begin
                        if (bear_ok)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= S_SIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SIN:
                begin
                    if (c_done)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_done)
                        state_reg <= (sq_root == '0) ? S_OUT : S_KW;
                end
                S_KW:   state_reg <= S_NUM;
                S_NUM:  state_reg <= S_DIVS;
                S_DIVS: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (dv_done)
                        state_reg <= S_ATN;
                end
                S_ATN:
                begin
                    if (c_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    last_goal_reg <= last_goal_next;
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                px_reg    <= pos_x;
                py_reg    <= pos_y;
                yaw_reg   <= heading;
                steer_reg <= '0;
            end
            S_HI:  lo2_reg <= prod_reg[33:0];
            S_HI2: hi2_reg <= prod_reg[33:0];
            S_DX:
            begin
                dx_reg   <= 25'(signed'(rd_x)) - 25'(px_reg);
                dy_reg   <= 25'(signed'(rd_y)) - 25'(py_reg);
                wyaw_reg <= rd_yaw;
            end
            S_SQY: sq_reg <= prod_reg[49:0];
            S_CMP:
            begin
                sum_reg      <= sum_sq;
                zero_off_reg <= (dx_reg == '0) && (dy_reg == '0);
            end
            S_BEAR: goal_reg <= i_reg[AW-1:0];
            S_SIN:  s_reg    <= c_yo;
            S_SQRT:
            begin
                dist_reg <= sq_root;
                if (s_reg > 0)
                    steer_reg <= 16'sh7FFF;
                else if (s_reg < 0)
                    steer_reg <= 16'sh8000;
                else
                    steer_reg <= '0;
            end
            S_DIVS: num_neg_reg <= num56[55];
            S_ATN:  steer_reg   <= steer_clamp;
            S_OUT:
            begin
                speed_reg     <= hit_reg ? SPEED_HIT : 9'd0;
                steer_out_reg <= hit_reg ? steer_reg : 16'sd0;
                found_reg     <= hit_reg;
                gpos_reg      <= hit_reg ? 10'(goal_reg) : 10'd0;
                stop_reg      <= !hit_reg;
                avail_reg     <= (path_count_reg >= CW'(2))
                                 && (({1'b0, CW'(last_goal_next)} + (CW + 1)'(REMAIN_MIN))
                                     < {1'b0, path_count_reg});
            end
            default: ;
        endcase
    end

    assign done           = done_reg;
    assign speed_cmd      = speed_reg;
    assign steering_cmd   = steer_out_reg;
    assign goal_found     = found_reg;
    assign goal_position  = gpos_reg;
    assign stop_request   = stop_reg;
    assign path_available = avail_reg;
endmodule
